// ===== hdl/nsp_pkg.sv =====
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types, constants and helpers for the number string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nsp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 16;
  localparam int CH_BITS    = 8;
  localparam int RADIX_BITS = 5;
  localparam int DIGIT_BITS = 5;   // 0..15 digit, 16 = not a hex digit
  localparam int OUT_BITS   = VALUE_BITS + COUNT_BITS;
  localparam int TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = 1;
  localparam int QCNT_BITS  = 2;

  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CH_BITS-1:0] CH_UP_A  = 8'h41;  // 'A'
  localparam logic [CH_BITS-1:0] CH_UP_F  = 8'h46;  // 'F'
  localparam logic [CH_BITS-1:0] CH_LO_A  = 8'h61;  // 'a'
  localparam logic [CH_BITS-1:0] CH_LO_F  = 8'h66;  // 'f'
  localparam logic [CH_BITS-1:0] CH_X     = 8'h78;  // 'x'

  localparam logic [RADIX_BITS-1:0] RADIX_HEX = 5'd16;
  localparam logic [RADIX_BITS-1:0] RADIX_OCT = 5'd8;
  localparam logic [RADIX_BITS-1:0] RADIX_DEC = 5'd10;
  localparam logic [DIGIT_BITS-1:0] NOT_HEX   = 5'd16;

  // One queued operation for the back end.
  typedef struct packed {
    logic                  clr;       // start over from zero value and count
    logic                  pre_bump;  // count one prefix character first
    logic                  dig;       // fold in one digit
    logic                  emit;      // deliver value and count
    logic [3:0]            digit;
    logic [RADIX_BITS-1:0] radix;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CH_BITS-1:0] c);
    logic [CH_BITS-1:0] t;
    begin
      t = CH_BITS'(NOT_HEX);
      if (c >= CH_ZERO && c <= CH_NINE) begin
        t = c - CH_ZERO;
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
        t = c - CH_UP_A + 8'd10;
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
        t = c - CH_LO_A + 8'd10;
      end
      return t[DIGIT_BITS-1:0];
    end
  endfunction

  // Configured radix, clamped to 16; zero selects the fallback.
  function automatic logic [RADIX_BITS-1:0] pick_radix(input logic [RADIX_BITS-1:0] setting,
                                                      input logic [RADIX_BITS-1:0] fallback);
    logic [RADIX_BITS-1:0] b;
    begin
      b = (setting > RADIX_HEX) ? RADIX_HEX : setting;
      return (b == '0) ? fallback : b;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/number_string_parser.sv =====
// ----------------------------------------------------------------------------
// number_string_parser
// Streaming unsigned number parser with radix prefix detection.
// ----------------------------------------------------------------------------
// Feed one character per beat on the slave side; tuser high marks the first
// character of a new string and restarts the parse. The radix comes from
// cfg_data (1..16, values above 16 act as 16, 0 = detect: leading '0' gives
// octal, else decimal); "0x" plus a hex digit always forces hex. The first
// non-digit ends the number and yields one beat with the value (mod 2^32)
// and the character count (saturating). One character is taken every cycle
// while the queue has room; a result goes through the op queue and then the
// output register. tready drops only when the two-entry op queue fills, i.e.
// while a result beat is held by master-side backpressure. Characters between
// strings give no result. Write cfg only while idle.
`default_nettype none

module number_string_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration: base_setting
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [nsp_pkg::RADIX_BITS-1:0] cfg_data,    // base_setting
  // character stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,     // [7:0] ch
  input  wire logic                           s_tuser,     // [0] first
  // results
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [nsp_pkg::TDATA_BITS-1:0]      m_tdata      // [31:0] value, [47:32] consumed
);
  import nsp_pkg::*;

  logic [RADIX_BITS-1:0] base_setting;
  logic                  push, pop;
  op_t                   push_op, head;
  q_status_t             q_stat;

  // Register write is always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_setting <= '0;
    end else if (cfg_valid) begin
      base_setting <= cfg_data;
    end
  end

  // Front: classify characters, track prefix phase and radix.
  nsp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .base_setting (base_setting),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .q_stat       (q_stat),
    .push         (push),
    .push_op      (push_op)
  );

  // Decoupling queue.
  nsp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  // Back: accumulate and deliver.
  nsp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// ===== hdl/nsp_front.sv =====
// ----------------------------------------------------------------------------
// nsp_front
// Accepts characters, tracks the prefix phase and radix, queues back-end ops.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [nsp_pkg::RADIX_BITS-1:0] base_setting,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,   // ch
  input  wire logic                           s_tuser,   // first
  input  wire nsp_pkg::q_status_t             q_stat,
  output logic                                push,
  output nsp_pkg::op_t                        push_op
);
  import nsp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_ZERO, PH_ZERO_X, PH_DIGITS, PH_DONE
  } phase_t;

  phase_t                phase, phase_next;
  logic [RADIX_BITS-1:0] radix, radix_next;
  logic [DIGIT_BITS-1:0] d;
  logic                  take;
  logic                  want;
  op_t                   op;

  assign s_tready = !q_stat.full;
  assign take     = s_tvalid && s_tready;
  assign d        = digit_of(s_tdata);

  always_comb begin
    phase_next = phase;
    radix_next = radix;
    want       = 1'b0;
    op         = '0;
    op.digit   = d[3:0];
    if (s_tuser) begin
      op.clr = 1'b1;
      want   = 1'b1;
      if (s_tdata == CH_ZERO) begin
        op.pre_bump = 1'b1;
        radix_next  = '0;
        phase_next  = PH_ZERO;
      end else begin
        radix_next = pick_radix(base_setting, RADIX_DEC);
      end
    end else begin
      unique case (phase)
        PH_ZERO: begin
          if (s_tdata == CH_X) begin
            phase_next = PH_ZERO_X;
          end else begin
            want       = 1'b1;
            radix_next = pick_radix(base_setting, RADIX_OCT);
          end
        end
        PH_ZERO_X: begin
          want = 1'b1;
          if (d < NOT_HEX) begin
            op.pre_bump = 1'b1;
            radix_next  = RADIX_HEX;
          end else begin
            radix_next = pick_radix(base_setting, RADIX_OCT);
          end
        end
        PH_DIGITS: want = 1'b1;
        default:   want = 1'b0;
      endcase
    end
    // Digit or terminator decision, unless the leading zero is being held.
    if (want && !(s_tuser && s_tdata == CH_ZERO)) begin
      if (d < radix_next) begin
        op.dig     = 1'b1;
        phase_next = PH_DIGITS;
      end else begin
        op.emit    = 1'b1;
        phase_next = PH_DONE;
      end
    end
    op.radix = radix_next;
  end

  assign push    = take && want;
  assign push_op = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      radix <= '0;
    end else if (take) begin
      phase <= phase_next;
      radix <= radix_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nsp_queue.sv =====
// ----------------------------------------------------------------------------
// nsp_queue
// Two-entry op queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire nsp_pkg::op_t push_op,
  input  wire logic         pop,
  output nsp_pkg::op_t      head,
  output nsp_pkg::q_status_t q_stat
);
  import nsp_pkg::*;

  op_t                  mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign q_stat.full  = (count == QCNT_BITS'(QDEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!q_stat.full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

// ===== hdl/nsp_back.sv =====
// ----------------------------------------------------------------------------
// nsp_back
// Executes queued ops: multiply-add accumulator, count, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire nsp_pkg::op_t                      head,
  input  wire nsp_pkg::q_status_t                q_stat,
  output logic                                   pop,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [nsp_pkg::TDATA_BITS-1:0]         m_tdata   // value, consumed
);
  import nsp_pkg::*;

  logic [VALUE_BITS-1:0] acc, acc_next, a0;
  logic [COUNT_BITS-1:0] cnt, cnt_next, c0, c1;
  logic [VALUE_BITS-1:0] out_value;
  logic [COUNT_BITS-1:0] out_count;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign pop = !q_stat.empty && (!head.emit || !m_tvalid || m_tready);

  always_comb begin
    a0       = head.clr ? '0 : acc;
    c0       = head.clr ? '0 : cnt;
    c1       = head.pre_bump ? sat_inc(c0) : c0;
    acc_next = a0;
    cnt_next = c1;
    if (head.dig) begin
      acc_next = a0 * VALUE_BITS'(head.radix) + VALUE_BITS'(head.digit);
      cnt_next = sat_inc(c1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        acc <= acc_next;
        cnt <= cnt_next;
      end
      if (pop && head.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.emit) begin
      out_value <= a0;
      out_count <= c1;
    end
  end

  assign m_tdata = TDATA_BITS'({out_count, out_value});

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (pop && head.emit) |-> (!m_tvalid || m_tready))
    else $error("emit overwrote a pending beat");
  a_digit_counts: assert property (@(posedge clk) disable iff (rst)
    (pop && head.dig) |=> (cnt != '0))
    else $error("digit left count at zero");
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (pop && head.emit) |=> m_tvalid)
    else $error("emit did not raise output valid");
`endif

endmodule

`default_nettype wire
